// ===== src/calendar_date_adder_assert.svh =====
// Assertion macros for the calendar date adder checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CALENDAR_DATE_ADDER_ASSERT_SVH
`define CALENDAR_DATE_ADDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_date_adder check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_date_adder check failed");

`endif

// ===== src/cda_pkg.sv =====
// Shared types, constants and calendar helpers for the calendar date adder.
// No dependencies; used by every design module of the block.
package cda_pkg;

    localparam int MONTHS_PER_YEAR    = 12;
    localparam int YEAR_CYCLE         = 400;
    localparam int YEAR_MAX           = 9999;
    localparam int QUEUE_DEPTH        = 2;

    // Month mode works on a biased month index so that it never goes negative.
    localparam int MONTH_OFFSET_YEARS = 3000;
    localparam int MONTH_INDEX_BIAS   = MONTHS_PER_YEAR * MONTH_OFFSET_YEARS;

    // Reciprocals scaled by 2**RECIP_SHIFT, exact for the operand ranges used here.
    localparam int RECIP_SHIFT        = 22;
    localparam int RECIP_MONTHS       = ((1 << RECIP_SHIFT) + MONTHS_PER_YEAR - 1)
                                        / MONTHS_PER_YEAR;
    localparam int RECIP_CYCLE        = ((1 << RECIP_SHIFT) + YEAR_CYCLE - 1) / YEAR_CYCLE;

    localparam logic [1:0] OP_DAYS   = 2'd0;
    localparam logic [1:0] OP_MONTHS = 2'd1;
    localparam logic [1:0] OP_YEARS  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DAYS,
        KIND_MONTHS,
        KIND_YEARS
    } kind_t;

    // One classified beat as it travels from the front end to the back end.
    typedef struct packed {
        kind_t        kind;
        logic [4:0]   day;
        logic [3:0]   month;
        logic [13:0]  year;
        logic         fwd;
        logic [15:0]  mag;
        logic [18:0]  tmon;
        logic [16:0]  ysum;
    } entry_t;

    localparam logic [4:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // The argument is the year modulo the 400-year cycle.
    function automatic logic is_leap(input logic [8:0] ymod);
        logic century;
        century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    // Months outside 1..12 count as 31 days long.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if ((month == 4'd0) || (month > 4'(MONTHS_PER_YEAR))) begin
            len = 5'd31;
        end
        else if ((month == 4'd2) && leap) begin
            len = 5'd29;
        end
        else begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

endpackage

// ===== src/cda_front.sv =====
// Front end: classifies each input beat and precomputes its operands.
// Depends on cda_pkg for the entry type, opcodes and constants.
module cda_front (
    input  logic               [1:0]  opcode,
    input  logic               [4:0]  day_in,
    input  logic               [3:0]  month_in,
    input  logic               [13:0] year_in,
    input  logic signed        [15:0] delta,
    output cda_pkg::entry_t           entry
);

    logic [15:0]        delta_u;
    logic signed [19:0] tmon_s;

    assign delta_u = delta;

    // Biased linear month index: year*12 + (month - 1) + delta + bias.
    assign tmon_s = $signed({6'b0, year_in}) * 20'sd12
                  + $signed({16'b0, month_in})
                  + $signed({{4{delta[15]}}, delta})
                  + 20'(cda_pkg::MONTH_INDEX_BIAS - 1);

    always_comb
    begin
        case (opcode)
            cda_pkg::OP_DAYS:   entry.kind = cda_pkg::KIND_DAYS;
            cda_pkg::OP_MONTHS: entry.kind = cda_pkg::KIND_MONTHS;
            default:            entry.kind = cda_pkg::KIND_YEARS;
        endcase
        entry.day   = day_in;
        entry.month = month_in;
        entry.year  = year_in;
        entry.fwd   = !delta[15] && (delta_u != 16'd0);
        entry.mag   = delta[15] ? (~delta_u + 16'd1) : delta_u;
        entry.tmon  = tmon_s[18:0];
        entry.ysum  = 17'($signed({3'b0, year_in}) + $signed({delta[15], delta}));
    end

endmodule

// ===== src/cda_fifo.sv =====
// Short queue that decouples the front end from the back end.
// Depends on cda_pkg for the entry type and the default depth (two or more).
module cda_fifo #(
    parameter int DEPTH = cda_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cda_pkg::entry_t  wdata,
    input  logic             pop,
    output logic             empty,
    output cda_pkg::entry_t  rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cda_pkg::entry_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/cda_back.sv =====
// Back end: carries out one queued beat at a time and holds the result register.
// Depends on cda_pkg for the entry type, calendar helpers and constants.
module cda_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  cda_pkg::entry_t  q_data,
    output logic             empty,
    input  logic             pop,
    output logic [4:0]       day_out,
    output logic [3:0]       month_out,
    output logic [13:0]      year_out,
    output logic             year_overflow
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    cda_pkg::kind_t       kind_reg, kind_next;
    logic [4:0]           d_reg, d_next;
    logic [3:0]           m_reg, m_next;
    logic signed [16:0]   y_reg, y_next;
    logic [8:0]           ymod_reg, ymod_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic                 fwd_reg, fwd_next;
    logic [18:0]          t_reg, t_next;
    logic [14:0]          q_reg, q_next;

    logic                 out_valid_reg, out_valid_next;
    logic [4:0]           day_out_reg;
    logic [3:0]           month_out_reg;
    logic [13:0]          year_out_reg;
    logic                 ovf_out_reg;

    logic                 fin_write;
    logic [18:0]          recip;
    logic [37:0]          prod;
    logic [18:0]          rem;
    logic [4:0]           dmax;
    logic [5:0]           steps;
    logic [3:0]           m_roll;
    logic signed [16:0]   y_roll;
    logic [8:0]           ymod_roll;
    logic [13:0]          year_clamped;
    logic                 ovf_clamped;

    assign empty         = !out_valid_reg;
    assign day_out       = day_out_reg;
    assign month_out     = month_out_reg;
    assign year_out      = year_out_reg;
    assign year_overflow = ovf_out_reg;

    // One shared reciprocal multiplier serves the month split and the year cycle.
    assign recip = (kind_reg == cda_pkg::KIND_MONTHS) ? 19'(cda_pkg::RECIP_MONTHS)
                                                      : 19'(cda_pkg::RECIP_CYCLE);
    assign prod  = {19'b0, t_reg} * {19'b0, recip};
    assign rem   = (kind_reg == cda_pkg::KIND_MONTHS)
                 ? t_reg - ({4'b0, q_reg} * 19'(cda_pkg::MONTHS_PER_YEAR))
                 : t_reg - ({4'b0, q_reg} * 19'(cda_pkg::YEAR_CYCLE));

    assign dmax = cda_pkg::days_in(m_reg, cda_pkg::is_leap(ymod_reg));

    // Days to walk before the current month is left, in the walk direction.
    always_comb
    begin
        if (fwd_reg) begin
            steps = (d_reg <= dmax) ? ({1'b0, dmax} - {1'b0, d_reg} + 6'd1) : 6'd1;
        end
        else begin
            steps = ((d_reg != 5'd0) && ({1'b0, d_reg} <= {1'b0, dmax} + 6'd1))
                  ? {1'b0, d_reg} : 6'd1;
        end
    end

    // Neighboring month; forward, months above 12 wrap as December does; backward, 0 and 14..15 wrap as January does.
    always_comb
    begin
        m_roll    = m_reg;
        y_roll    = y_reg;
        ymod_roll = ymod_reg;
        if (fwd_reg) begin
            if (m_reg >= 4'(cda_pkg::MONTHS_PER_YEAR)) begin
                m_roll    = 4'd1;
                y_roll    = y_reg + 17'sd1;
                ymod_roll = (ymod_reg == 9'(cda_pkg::YEAR_CYCLE - 1)) ? 9'd0 : ymod_reg + 9'd1;
            end
            else begin
                m_roll = m_reg + 4'd1;
            end
        end
        else begin
            if ((m_reg <= 4'd1) || (m_reg >= 4'(cda_pkg::MONTHS_PER_YEAR + 2))) begin
                m_roll    = 4'(cda_pkg::MONTHS_PER_YEAR);
                y_roll    = y_reg - 17'sd1;
                ymod_roll = (ymod_reg == 9'd0) ? 9'(cda_pkg::YEAR_CYCLE - 1) : ymod_reg - 9'd1;
            end
            else begin
                m_roll = m_reg - 4'd1;
            end
        end
    end

    always_comb
    begin
        if (y_reg < 17'sd0) begin
            year_clamped = 14'd0;
            ovf_clamped  = 1'b1;
        end
        else if (y_reg > 17'(cda_pkg::YEAR_MAX)) begin
            year_clamped = 14'(cda_pkg::YEAR_MAX);
            ovf_clamped  = 1'b1;
        end
        else begin
            year_clamped = y_reg[13:0];
            ovf_clamped  = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        ymod_next  = ymod_reg;
        cnt_next   = cnt_reg;
        fwd_next   = fwd_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        q_pop      = 1'b0;
        fin_write  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    kind_next = q_data.kind;
                    d_next    = q_data.day;
                    m_next    = q_data.month;
                    fwd_next  = q_data.fwd;
                    cnt_next  = q_data.mag;
                    if (q_data.kind == cda_pkg::KIND_YEARS) begin
                        y_next     = $signed(q_data.ysum);
                        state_next = S_FIN;
                    end
                    else begin
                        y_next     = $signed({3'b0, q_data.year});
                        t_next     = (q_data.kind == cda_pkg::KIND_MONTHS)
                                   ? q_data.tmon : {5'b0, q_data.year};
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                q_next     = prod[cda_pkg::RECIP_SHIFT +: 15];
                state_next = S_FIX;
            end
            S_FIX: begin
                if (kind_reg == cda_pkg::KIND_MONTHS) begin
                    y_next     = $signed({2'b0, q_reg}) - 17'(cda_pkg::MONTH_OFFSET_YEARS);
                    m_next     = rem[3:0] + 4'd1;
                    state_next = S_FIN;
                end
                else begin
                    ymod_next  = rem[8:0];
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (cnt_reg == 16'd0) begin
                    state_next = S_FIN;
                end
                else if (cnt_reg < {10'b0, steps}) begin
                    d_next     = fwd_reg ? d_reg + cnt_reg[4:0] : d_reg - cnt_reg[4:0];
                    cnt_next   = 16'd0;
                    state_next = S_FIN;
                end
                else begin
                    cnt_next  = cnt_reg - {10'b0, steps};
                    m_next    = m_roll;
                    y_next    = y_roll;
                    ymod_next = ymod_roll;
                    d_next    = fwd_reg ? 5'd1
                              : cda_pkg::days_in(m_roll, cda_pkg::is_leap(ymod_roll));
                end
            end
            S_FIN: begin
                if (!out_valid_reg || pop) begin
                    fin_write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !pop) || fin_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            kind_reg      <= cda_pkg::KIND_DAYS;
            fwd_reg       <= 1'b0;
            cnt_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            fwd_reg       <= fwd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        ymod_reg <= ymod_next;
        t_reg    <= t_next;
        q_reg    <= q_next;
        if (fin_write) begin
            day_out_reg   <= d_reg;
            month_out_reg <= m_reg;
            year_out_reg  <= year_clamped;
            ovf_out_reg   <= ovf_clamped;
        end
    end

endmodule

// ===== src/calendar_date_adder.sv =====
// Top level of the calendar date adder: front end, queue and back end.
// Depends on cda_pkg, cda_front, cda_fifo and cda_back.
//
// Shifts a Gregorian date by a signed count of days, months or years and
// returns one result beat per input beat, in order. Opcode 0 walks days one
// month per cycle through the back end's month-step loop; month beats only
// pass the multiply and fix states, and year beats go straight to the finish
// state. Month and year modes pass the day through unclamped. A result
// year outside 0..9999 is clamped to the nearest bound and year_overflow is
// set. The input queue holds QUEUE_DEPTH beats (two or more), so new beats
// are accepted while an earlier one is still being worked on or waits to be
// popped.
module calendar_date_adder #(
    parameter int QUEUE_DEPTH = cda_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic        [1:0]  opcode,
    input  logic        [4:0]  day_in,
    input  logic        [3:0]  month_in,
    input  logic        [13:0] year_in,
    input  logic signed [15:0] delta,
    output logic               empty,
    input  logic               pop,
    output logic        [4:0]  day_out,
    output logic        [3:0]  month_out,
    output logic        [13:0] year_out,
    output logic               year_overflow
);

    cda_pkg::entry_t front_entry;
    cda_pkg::entry_t q_data;
    logic            q_empty;
    logic            q_pop;

    cda_front u_front (
        .opcode   (opcode),
        .day_in   (day_in),
        .month_in (month_in),
        .year_in  (year_in),
        .delta    (delta),
        .entry    (front_entry)
    );

    cda_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_entry),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_data)
    );

    cda_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .empty         (empty),
        .pop           (pop),
        .day_out       (day_out),
        .month_out     (month_out),
        .year_out      (year_out),
        .year_overflow (year_overflow)
    );

endmodule

// ===== src/cda_checker.sv =====
// Port-level checker for the calendar date adder, bound to the top level.
// Depends on calendar_date_adder_assert.svh for the assertion macros.
`include "calendar_date_adder_assert.svh"

module cda_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic        [1:0]  opcode,
    input logic        [4:0]  day_in,
    input logic        [3:0]  month_in,
    input logic        [13:0] year_in,
    input logic signed [15:0] delta,
    input logic               empty,
    input logic               pop,
    input logic        [4:0]  day_out,
    input logic        [3:0]  month_out,
    input logic        [13:0] year_out,
    input logic               year_overflow
);

    logic [23:0] result_bits;
    logic        year_on_bound;

    assign result_bits   = {day_out, month_out, year_out, year_overflow};
    assign year_on_bound = (year_out == 14'd0) || (year_out == 14'd9999);

    // A shown year is always clamped into range.
    `CDA_ASSERT_NOW(a_year_in_range, !empty, year_out <= 14'd9999)

    // An overflowed year sits on one of the two bounds.
    `CDA_ASSERT_NOW(a_ovf_on_bound, !empty && year_overflow, year_on_bound)

    // A result beat that is not popped stays put with the same payload.
    `CDA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result_bits))

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);
